FILE: hdl/moc_pkg.sv
// Shared types and constants for the Manhattan-order cell scan.
package moc_pkg;

   localparam int MAX_SIDE = 64;
   localparam int ROW_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int DIST_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_SIDE);

   // scan position: distance, row, right-hand column pending
   typedef struct packed {
      logic [DIST_W-1:0] d;
      logic [ROW_W-1:0]  r;
      logic              side;
   } pos_type;

   // clamped geometry of the grid
   typedef struct packed {
      logic [SIZE_W-1:0] rows;
      logic [SIZE_W-1:0] cols;
      logic [ROW_W-1:0]  cr;
      logic [ROW_W-1:0]  cc;
      logic [DIST_W-1:0] maxd;
   } geom_type;

   // outcome of one step of the scan unit
   typedef struct packed {
      logic             exhausted;
      logic             found;
      logic [ROW_W-1:0] col;
      pos_type          nxt;
   } step_type;

endpackage

FILE: hdl/manhattan_order_cell_scan.sv
// Top level of the Manhattan-order cell scan: configuration registers and sequencer.
//
// Usage: configure grid_rows, grid_cols, center_row and center_col through
// the csr_ write port (index 0..3) while the block is idle. Each item on the
// req_ channel (restart = 1 starts over at distance zero, 0 advances) gives
// exactly one item on the rsp_ channel: the next cell in order of distance
// to the centre, then row, then column, with last_cell on the final cell,
// or scan_done (other fields zero) once the grid is exhausted.
// Operation: a set-up step, then the step unit walks the candidate positions
// until it finds the cell, then walks on to look ahead for last_cell, then
// the result is registered; the walk is longer when many rows lie outside
// the current distance band. The single step unit sets the rate;
// req_ready is high only between items.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled rsp_ready holds the following result in the sequencer.
// Reset (synchronous) restores the register defaults and the start of scan.
module manhattan_order_cell_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [moc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [moc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [moc_pkg::ROW_W-1:0]         rsp_cell_row,
   output logic [moc_pkg::ROW_W-1:0]         rsp_cell_col,
   output logic [moc_pkg::DIST_W-1:0]        rsp_cell_distance,
   output logic                              rsp_last_cell,
   output logic                              rsp_scan_done
);

   logic [moc_pkg::SIZE_W-1:0] grid_rows_ff, grid_rows_in;
   logic [moc_pkg::SIZE_W-1:0] grid_cols_ff, grid_cols_in;
   logic [moc_pkg::ROW_W-1:0]  center_row_ff, center_row_in;
   logic [moc_pkg::ROW_W-1:0]  center_col_ff, center_col_in;

   logic [moc_pkg::ROW_W-1:0]  rows_m1, cols_m1, span_r, span_c;
   moc_pkg::geom_type          geom;

   always_comb begin
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      center_row_in = center_row_ff;
      center_col_in = center_col_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            moc_pkg::CSR_GRID_ROWS:  grid_rows_in  = csr_wdata;
            moc_pkg::CSR_GRID_COLS:  grid_cols_in  = csr_wdata;
            moc_pkg::CSR_CENTER_ROW: center_row_in = csr_wdata[moc_pkg::ROW_W-1:0];
            moc_pkg::CSR_CENTER_COL: center_col_in = csr_wdata[moc_pkg::ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff  <= moc_pkg::SIZE_W'(1);
         grid_cols_ff  <= moc_pkg::SIZE_W'(1);
         center_row_ff <= '0;
         center_col_ff <= '0;
      end else begin
         grid_rows_ff  <= grid_rows_in;
         grid_cols_ff  <= grid_cols_in;
         center_row_ff <= center_row_in;
         center_col_ff <= center_col_in;
      end
   end

   // clamp sizes and centre, find the largest distance in the grid
   always_comb begin
      priority if (grid_rows_ff == '0)               geom.rows = moc_pkg::SIZE_W'(1);
      else if (grid_rows_ff > moc_pkg::SIZE_MAX)    geom.rows = moc_pkg::SIZE_MAX;
      else                                          geom.rows = grid_rows_ff;
      priority if (grid_cols_ff == '0)               geom.cols = moc_pkg::SIZE_W'(1);
      else if (grid_cols_ff > moc_pkg::SIZE_MAX)    geom.cols = moc_pkg::SIZE_MAX;
      else                                          geom.cols = grid_cols_ff;
      rows_m1 = moc_pkg::ROW_W'(geom.rows - moc_pkg::SIZE_W'(1));
      cols_m1 = moc_pkg::ROW_W'(geom.cols - moc_pkg::SIZE_W'(1));
      geom.cr = (center_row_ff > rows_m1) ? rows_m1 : center_row_ff;
      geom.cc = (center_col_ff > cols_m1) ? cols_m1 : center_col_ff;
      span_r  = (geom.cr > rows_m1 - geom.cr) ? geom.cr : rows_m1 - geom.cr;
      span_c  = (geom.cc > cols_m1 - geom.cc) ? geom.cc : cols_m1 - geom.cc;
      geom.maxd = {1'b0, span_r} + {1'b0, span_c};
   end

   moc_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .geom_cfg          (geom),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_distance (rsp_cell_distance),
      .rsp_last_cell     (rsp_last_cell),
      .rsp_scan_done     (rsp_scan_done)
   );

endmodule

FILE: hdl/moc_step.sv
// Scan step unit: examines one candidate position and gives the next one.
module moc_step (
   input  moc_pkg::pos_type  pos,
   input  moc_pkg::geom_type geom,
   output moc_pkg::step_type step
);

   logic [moc_pkg::ROW_W-1:0]  dr;
   logic [moc_pkg::DIST_W-1:0] k;
   logic                       in_band;
   logic                       left_ok;
   logic                       right_ok;
   logic [moc_pkg::DIST_W:0]   right_sum;
   logic [moc_pkg::SIZE_W-1:0] row_inc;
   moc_pkg::pos_type           row_pos;

   always_comb begin
      dr        = (pos.r >= geom.cr) ? pos.r - geom.cr : geom.cr - pos.r;
      in_band   = {1'b0, dr} <= pos.d;
      k         = pos.d - {1'b0, dr};
      left_ok   = !pos.side && (k <= {1'b0, geom.cc});
      right_sum = {2'b00, geom.cc} + {1'b0, k};
      right_ok  = (k != '0) && (right_sum < {1'b0, geom.cols});

      row_inc = {1'b0, pos.r} + moc_pkg::SIZE_W'(1);
      if (row_inc >= geom.rows) begin
         row_pos.d    = pos.d + moc_pkg::DIST_W'(1);
         row_pos.r    = '0;
         row_pos.side = 1'b0;
      end else begin
         row_pos.d    = pos.d;
         row_pos.r    = row_inc[moc_pkg::ROW_W-1:0];
         row_pos.side = 1'b0;
      end

      step.exhausted = pos.d > geom.maxd;
      step.found     = 1'b0;
      step.col       = '0;
      step.nxt       = row_pos;
      if (!step.exhausted && in_band) begin
         if (left_ok) begin
            step.found = 1'b1;
            step.col   = geom.cc - k[moc_pkg::ROW_W-1:0];
            if (k != '0) begin
               step.nxt.d    = pos.d;
               step.nxt.r    = pos.r;
               step.nxt.side = 1'b1;
            end
         end else if (right_ok) begin
            step.found = 1'b1;
            step.col   = right_sum[moc_pkg::ROW_W-1:0];
         end
      end
   end

endmodule

FILE: hdl/moc_seq.sv
// Scan sequencer: holds the scan position and drives the shared step unit.
module moc_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  moc_pkg::geom_type           geom_cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [moc_pkg::ROW_W-1:0]   rsp_cell_row,
   output logic [moc_pkg::ROW_W-1:0]   rsp_cell_col,
   output logic [moc_pkg::DIST_W-1:0]  rsp_cell_distance,
   output logic                        rsp_last_cell,
   output logic                        rsp_scan_done
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_FIND = 2'd2;
   localparam logic [1:0] ST_LOOK = 2'd3;

   logic [1:0]                 state_ff, state_in;
   moc_pkg::pos_type           cur_ff, cur_in;
   logic                       fin_ff, fin_in;
   moc_pkg::pos_type           walk_ff, walk_in;
   moc_pkg::geom_type          geom_ff, geom_in;
   logic [moc_pkg::ROW_W-1:0]  hit_row_ff, hit_row_in;
   logic [moc_pkg::ROW_W-1:0]  hit_col_ff, hit_col_in;
   logic [moc_pkg::DIST_W-1:0] hit_dist_ff, hit_dist_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [moc_pkg::ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [moc_pkg::ROW_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [moc_pkg::DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_done_ff, rsp_done_in;

   logic                       out_free;
   logic                       emit, emit_done, emit_last;
   moc_pkg::step_type          step;

   moc_step u_step (
      .pos  (walk_ff),
      .geom (geom_ff),
      .step (step)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      fin_in      = fin_ff;
      walk_in     = walk_ff;
      geom_in     = geom_ff;
      hit_row_in  = hit_row_ff;
      hit_col_in  = hit_col_ff;
      hit_dist_in = hit_dist_ff;
      emit        = 1'b0;
      emit_done   = 1'b0;
      emit_last   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               geom_in = geom_cfg;
               if (req_restart) begin
                  cur_in = '0;
                  fin_in = 1'b0;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (fin_ff) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               // stored row may lie past a shrunken grid
               if ({1'b0, cur_ff.r} >= geom_ff.rows) begin
                  walk_in.d    = cur_ff.d + moc_pkg::DIST_W'(1);
                  walk_in.r    = '0;
                  walk_in.side = 1'b0;
               end else begin
                  walk_in = cur_ff;
               end
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (step.exhausted) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_done = 1'b1;
                  fin_in    = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (step.found) begin
               hit_row_in  = walk_ff.r;
               hit_col_in  = step.col;
               hit_dist_in = walk_ff.d;
               cur_in      = step.nxt;
               walk_in     = step.nxt;
               state_in    = ST_LOOK;
            end else begin
               walk_in = step.nxt;
            end
         end
         ST_LOOK: begin
            if (step.exhausted) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  fin_in    = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (step.found) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               walk_in = step.nxt;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_done_in  = emit_done;
         rsp_last_in  = emit_last;
         rsp_row_in   = emit_done ? '0 : hit_row_ff;
         rsp_col_in   = emit_done ? '0 : hit_col_ff;
         rsp_dist_in  = emit_done ? '0 : hit_dist_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      geom_ff     <= geom_in;
      hit_row_ff  <= hit_row_in;
      hit_col_ff  <= hit_col_in;
      hit_dist_ff <= hit_dist_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_row      = rsp_row_ff;
   assign rsp_cell_col      = rsp_col_ff;
   assign rsp_cell_distance = rsp_dist_ff;
   assign rsp_last_cell     = rsp_last_ff;
   assign rsp_scan_done     = rsp_done_ff;

endmodule

FILE: hdl/moc_checker.sv
// Port-level checks for the Manhattan-order cell scan, bound to the top level.
module moc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [moc_pkg::ROW_W-1:0]  rsp_cell_row,
   input logic [moc_pkg::ROW_W-1:0]  rsp_cell_col,
   input logic [moc_pkg::DIST_W-1:0] rsp_cell_distance,
   input logic                       rsp_last_cell,
   input logic                       rsp_scan_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_row)
         && $stable(rsp_cell_col) && $stable(rsp_cell_distance)
         && $stable(rsp_last_cell) && $stable(rsp_scan_done))
      else $error("result item changed while stalled");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_done |-> rsp_cell_row == '0 && rsp_cell_col == '0
         && rsp_cell_distance == '0 && !rsp_last_cell)
      else $error("done item carries cell data");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after an accepted item");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind manhattan_order_cell_scan moc_checker u_moc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_cell_row      (rsp_cell_row),
   .rsp_cell_col      (rsp_cell_col),
   .rsp_cell_distance (rsp_cell_distance),
   .rsp_last_cell     (rsp_last_cell),
   .rsp_scan_done     (rsp_scan_done)
);
